### rtl/sss_pkg.sv
// Shared types and constants of the segregation satisfaction stencil.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int QUEUE_DEPTH  = 4;
    localparam int BUNDLE_SLOTS = 3;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_GRID_ROWS  = 3'd1;
    localparam logic [2:0] REG_BASE_INDEX = 3'd2;
    localparam logic [2:0] REG_FIRST_EVAL = 3'd3;
    localparam logic [2:0] REG_LAST_EVAL  = 3'd4;
    localparam logic [2:0] REG_MOVE_LIMIT = 3'd5;

    localparam logic [9:0]  RST_THRESHOLD  = 10'd333;
    localparam logic [6:0]  RST_GRID_ROWS  = 7'd64;
    localparam logic [15:0] RST_BASE_INDEX = 16'd0;
    localparam logic [5:0]  RST_FIRST_EVAL = 6'd0;
    localparam logic [5:0]  RST_LAST_EVAL  = 6'd63;
    localparam logic [11:0] RST_MOVE_LIMIT = 12'd2048;

    localparam logic [1:0] KIND_EMPTY   = 2'd0;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    typedef struct packed {
        logic [9:0]  threshold_tenths;
        logic [6:0]  grid_rows;
        logic [15:0] base_index;
        logic [5:0]  first_eval_row;
        logic [5:0]  last_eval_row;
        logic [11:0] move_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cell_index;
        logic [1:0]  kind;
        logic [3:0]  same_count;
        logic [3:0]  neighbour_count;
        logic        eval;
        logic        last;
    } report_t;

    typedef struct packed {
        logic [1:0]                       count;
        report_t [BUNDLE_SLOTS-1:0]       item;
    } bundle_t;

endpackage

### rtl/sss_cell_if.sv
// Input channel: one grid cell per transfer.
`timescale 1ns / 1ps

interface sss_cell_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_kind;

    modport source (output valid, output cell_kind, input ready);
    modport sink (input valid, input cell_kind, output ready);
endinterface

### rtl/sss_result_if.sv
// Output channel: one evaluated cell per transfer.
`timescale 1ns / 1ps

interface sss_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_index;
    logic [1:0]  kind;
    logic [3:0]  same_count;
    logic [3:0]  neighbour_count;
    logic        unsatisfied;
    logic        selected_to_move;
    logic        last_of_run;

    modport source (output valid, output cell_index, output kind, output same_count,
                    output neighbour_count, output unsatisfied, output selected_to_move,
                    output last_of_run, input ready);
    modport sink (input valid, input cell_index, input kind, input same_count,
                  input neighbour_count, input unsatisfied, input selected_to_move,
                  input last_of_run, output ready);
endinterface

### rtl/sss_queue.sv
// Short bundle queue between the stencil front end and the result back end.
`timescale 1ns / 1ps

module sss_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sss_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output sss_pkg::bundle_t head,
    output logic             empty
);

    localparam int DEPTH = sss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sss_pkg::bundle_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("bundle queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("bundle queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("bundle queue count out of range");

endmodule

### rtl/sss_front.sv
// Front end: line store, 3x3 window and neighbour counting; issues report bundles.
`timescale 1ns / 1ps

module sss_front #(
    parameter int COLUMNS  = 32,
    parameter int MAX_ROWS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    sss_cell_if.sink         cell_stream,
    input  sss_pkg::cfg_t    cfg,
    input  logic             q_full,
    output logic             q_push,
    output sss_pkg::bundle_t q_data
);

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DCOL_W = $clog2(COLUMNS + 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [DCOL_W-1:0] DRAIN_END = DCOL_W'(COLUMNS);
    localparam logic [DCOL_W-1:0] READ_END  = DCOL_W'(COLUMNS - 1);
    localparam logic [6:0]        ROWS_MIN  = 7'd2;
    localparam logic [6:0]        ROWS_MAX  = 7'(MAX_ROWS);

    typedef enum logic {RUN, DRAIN} state_t;

    // k2 oldest row, k0 newest row of one column
    typedef struct packed {
        logic [1:0] k2;
        logic [1:0] k1;
        logic [1:0] k0;
    } column_t;

    typedef struct packed {
        logic [1:0] cur;
        logic [1:0] prev;
    } line_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] same;
        logic [3:0] neigh;
    } count_t;

    // upper: center in k1 with rows above and below; else center in k0, no row below
    function automatic count_t window_count(input column_t l, input column_t m,
                                            input column_t r, input logic lv,
                                            input logic rv, input logic upper,
                                            input logic topv);
        logic [7:0][1:0] nb;
        logic [7:0]      nv;
        count_t          res;
        if (upper)
        begin
            res.kind = m.k1;
            nb = {l.k2, m.k2, r.k2, l.k1, r.k1, l.k0, m.k0, r.k0};
            nv = {topv & lv, topv, topv & rv, lv, rv, lv, 1'b1, rv};
        end
        else
        begin
            res.kind = m.k0;
            nb = {l.k1, m.k1, r.k1, l.k0, r.k0, 6'b000000};
            nv = {lv, 1'b1, rv, lv, rv, 3'b000};
        end
        res.same  = '0;
        res.neigh = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (nv[i])
            begin
                res.neigh = res.neigh + 4'd1;
                if (res.kind != sss_pkg::KIND_EMPTY && nb[i] == res.kind)
                begin
                    res.same = res.same + 4'd1;
                end
            end
        end
        return res;
    endfunction

    function automatic sss_pkg::report_t make_report(input count_t cnt,
                                                     input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col,
                                                     input logic last,
                                                     input sss_pkg::cfg_t cf);
        sss_pkg::report_t rep;
        rep.cell_index      = 16'(cf.base_index + 16'(row) * 16'(COLUMNS) + 16'(col));
        rep.kind            = cnt.kind;
        rep.same_count      = cnt.same;
        rep.neighbour_count = cnt.neigh;
        rep.eval            = (cnt.kind != sss_pkg::KIND_EMPTY)
                              && (6'(row) >= cf.first_eval_row)
                              && (6'(row) <= cf.last_eval_row);
        rep.last            = last;
        return rep;
    endfunction

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [DCOL_W-1:0] dcol_reg, dcol_next;
    logic [ROW_W-1:0]  drain_row_reg, drain_row_next;

    line_word_t        line_mem [COLUMNS];
    line_word_t        rd_word_reg;
    column_t           left_reg, mid_reg;
    column_t           right_col;

    logic [1:0]        kind_in;
    logic [6:0]        rows_eff;
    logic              fin, accept, dstep, advance;
    logic              has_row, has_col, at_last, top_ok, left_ok;
    logic              need_a, need_b, need_c;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  row_up;
    logic [COL_W-1:0]  col_up;
    count_t            cnt_a, cnt_b, cnt_c, cnt_d;
    sss_pkg::report_t  rep_a, rep_b, rep_c, rep_d;

    assign kind_in = (cell_stream.cell_kind == sss_pkg::KIND_INVALID)
                     ? sss_pkg::KIND_EMPTY : cell_stream.cell_kind;
    assign rows_eff = (cfg.grid_rows < ROWS_MIN) ? ROWS_MIN
                      : ((cfg.grid_rows > ROWS_MAX) ? ROWS_MAX : cfg.grid_rows);
    assign fin = (7'(in_row_reg) >= (rows_eff - 7'd1));

    assign cell_stream.ready = (state_reg == RUN) && !q_full;
    assign accept  = cell_stream.ready && cell_stream.valid;
    assign dstep   = (state_reg == DRAIN) && !q_full;
    assign advance = accept || dstep;

    assign has_row = (in_row_reg != '0);
    assign has_col = (in_col_reg != '0);
    assign at_last = (in_col_reg == LAST_COL);
    assign top_ok  = (7'(in_row_reg) >= 7'd2);
    assign left_ok = (6'(in_col_reg) >= 6'd2);
    assign row_up  = ROW_W'(in_row_reg - 1'b1);
    assign col_up  = COL_W'(in_col_reg - 1'b1);

    assign right_col = (state_reg == RUN)
                       ? {rd_word_reg.prev, rd_word_reg.cur, kind_in}
                       : {sss_pkg::KIND_EMPTY, rd_word_reg.prev, rd_word_reg.cur};

    assign cnt_a = window_count(left_reg, mid_reg, right_col, left_ok, 1'b1, 1'b1, top_ok);
    assign cnt_b = window_count(left_reg, mid_reg, right_col, 1'b0, 1'b1, 1'b0, 1'b1);
    assign cnt_c = window_count(mid_reg, right_col, right_col, 1'b1, 1'b0, 1'b1, top_ok);
    assign cnt_d = window_count(left_reg, mid_reg, right_col, 1'b1,
                                dcol_reg != DRAIN_END, 1'b0, 1'b1);

    assign rep_a = make_report(cnt_a, row_up, col_up, 1'b0, cfg);
    assign rep_b = make_report(cnt_b, in_row_reg, '0, 1'b0, cfg);
    assign rep_c = make_report(cnt_c, row_up, LAST_COL, 1'b0, cfg);
    assign rep_d = make_report(cnt_d, drain_row_reg, COL_W'(dcol_reg - 1'b1),
                               dcol_reg == DRAIN_END, cfg);

    assign need_a = has_row && has_col;
    assign need_b = fin && has_row && (in_col_reg == COL_W'(1));
    assign need_c = at_last && has_row;

    always_comb
    begin
        if (state_reg == RUN)
        begin
            q_data.item[0] = rep_a;
            q_data.item[1] = need_b ? rep_b : rep_c;
            q_data.item[2] = rep_c;
            q_data.count   = 2'(need_a) + 2'(need_b) + 2'(need_c);
        end
        else
        begin
            q_data.item[0] = rep_d;
            q_data.item[1] = rep_d;
            q_data.item[2] = rep_d;
            q_data.count   = (dcol_reg >= DCOL_W'(2)) ? 2'd1 : 2'd0;
        end
    end

    assign q_push = advance && (q_data.count != 2'd0);

    // line store port: prefetch next column while running, walk the final row in drain
    always_comb
    begin
        if (state_reg == RUN)
        begin
            rd_en   = accept;
            rd_addr = at_last ? '0 : COL_W'(in_col_reg + 1'b1);
        end
        else
        begin
            rd_en   = dstep && (dcol_reg < READ_END);
            rd_addr = COL_W'(dcol_reg + 1'b1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        dcol_next      = dcol_reg;
        drain_row_next = drain_row_reg;
        case (state_reg)
            RUN:
            begin
                if (accept)
                begin
                    if (at_last)
                    begin
                        in_col_next = '0;
                        if (fin)
                        begin
                            state_next     = DRAIN;
                            in_row_next    = '0;
                            dcol_next      = '0;
                            drain_row_next = in_row_reg;
                        end
                        else
                        begin
                            in_row_next = ROW_W'(in_row_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        in_col_next = COL_W'(in_col_reg + 1'b1);
                    end
                end
            end
            DRAIN:
            begin
                if (dstep)
                begin
                    if (dcol_reg == DRAIN_END)
                    begin
                        state_next = RUN;
                        dcol_next  = '0;
                    end
                    else
                    begin
                        dcol_next = DCOL_W'(dcol_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RUN;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            dcol_reg      <= '0;
            drain_row_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            dcol_reg      <= dcol_next;
            drain_row_reg <= drain_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[in_col_reg] <= '{cur: kind_in, prev: rd_word_reg.cur};
        end
        if (rd_en)
        begin
            rd_word_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg <= mid_reg;
            mid_reg  <= right_col;
        end
    end

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DRAIN |-> dcol_reg <= DRAIN_END)
        else $error("drain column past end of row");
    a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
        accept && at_last && fin |=> state_reg == DRAIN && in_row_reg == '0)
        else $error("final cell did not start the row drain");

endmodule

### rtl/sss_back.sv
// Back end: threshold test, move selection and the output register.
`timescale 1ns / 1ps

module sss_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sss_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  sss_pkg::bundle_t q_head,
    output logic             q_pop,
    sss_result_if.source     result_stream
);

    localparam logic [13:0] SAME_SCALE = 14'd1000;

    logic [1:0]       slot_reg, slot_next;
    logic [11:0]      moved_reg, moved_next;
    logic             out_valid_reg, out_valid_next;

    logic [15:0]      cell_index_reg;
    logic [1:0]       kind_reg;
    logic [3:0]       same_reg;
    logic [3:0]       neigh_reg;
    logic             unsat_reg;
    logic             sel_reg;
    logic             last_reg;

    sss_pkg::report_t item;
    logic             load, last_slot, unsat, sel;

    assign item      = q_head.item[slot_reg];
    assign load      = !q_empty && (!out_valid_reg || result_stream.ready);
    assign last_slot = (slot_reg == 2'(q_head.count - 2'd1));
    assign q_pop     = load && last_slot;

    assign unsat = item.eval
                   && ((14'(item.same_count) * SAME_SCALE)
                       < (14'(cfg.threshold_tenths) * 14'(item.neighbour_count)));
    assign sel   = unsat && (moved_reg < cfg.move_limit);

    always_comb
    begin
        slot_next      = slot_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            slot_next      = last_slot ? 2'd0 : 2'(slot_reg + 2'd1);
            if (item.last)
            begin
                moved_next = '0;
            end
            else if (sel)
            begin
                moved_next = 12'(moved_reg + 12'd1);
            end
        end
        else if (result_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            moved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_index_reg <= item.cell_index;
            kind_reg       <= item.kind;
            same_reg       <= item.same_count;
            neigh_reg      <= item.neighbour_count;
            unsat_reg      <= unsat;
            sel_reg        <= sel;
            last_reg       <= item.last;
        end
    end

    assign result_stream.valid            = out_valid_reg;
    assign result_stream.cell_index       = cell_index_reg;
    assign result_stream.kind             = kind_reg;
    assign result_stream.same_count       = same_reg;
    assign result_stream.neighbour_count  = neigh_reg;
    assign result_stream.unsatisfied      = unsat_reg;
    assign result_stream.selected_to_move = sel_reg;
    assign result_stream.last_of_run      = last_reg;

endmodule

### rtl/segregation_satisfaction_stencil_unit.sv
// Top level: configuration registers and the front end, queue and back end.
//
// Grid cells enter on cell_stream in raster order, COLUMNS per row, grid_rows
// rows (2..MAX_ROWS) per run; one result per cell leaves on result_stream.
// Configuration goes through the APB-style port; write only while idle.
// A cell's result is registered in the bundle queue, then in the output register,
// once the cell one row below and one column right of it is transferred; cells
// in the last column of a row report with the last cell of the row below.
// Throughput: one cell per cycle, one result per cycle, while the queue has
// room and the receiver is ready. After the final cell of a run the input stays
// not ready while the final row is read back from the line store and reported.
// The output register lets the next result be computed while one waits;
// a stalled receiver fills the four-entry bundle queue, then input ready drops.
// Reset clears counters, the queue and the output valid, and loads the
// register defaults; the line store is not cleared and need not be.
`timescale 1ns / 1ps

module segregation_satisfaction_stencil_unit #(
    parameter int COLUMNS  = 32,
    parameter int MAX_ROWS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sss_cell_if.sink                   cell_stream,
    sss_result_if.source               result_stream,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sss_pkg::ADDR_W-1:0] paddr,
    input  logic [sss_pkg::DATA_W-1:0] pwdata,
    output logic [sss_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sss_pkg::cfg_t    cfg_reg;
    sss_pkg::bundle_t push_data, head;
    logic             push, full, pop, empty, wr_en;
    logic [2:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_tenths <= sss_pkg::RST_THRESHOLD;
            cfg_reg.grid_rows        <= sss_pkg::RST_GRID_ROWS;
            cfg_reg.base_index       <= sss_pkg::RST_BASE_INDEX;
            cfg_reg.first_eval_row   <= sss_pkg::RST_FIRST_EVAL;
            cfg_reg.last_eval_row    <= sss_pkg::RST_LAST_EVAL;
            cfg_reg.move_limit       <= sss_pkg::RST_MOVE_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                sss_pkg::REG_THRESHOLD:  cfg_reg.threshold_tenths <= pwdata[9:0];
                sss_pkg::REG_GRID_ROWS:  cfg_reg.grid_rows        <= pwdata[6:0];
                sss_pkg::REG_BASE_INDEX: cfg_reg.base_index       <= pwdata[15:0];
                sss_pkg::REG_FIRST_EVAL: cfg_reg.first_eval_row   <= pwdata[5:0];
                sss_pkg::REG_LAST_EVAL:  cfg_reg.last_eval_row    <= pwdata[5:0];
                sss_pkg::REG_MOVE_LIMIT: cfg_reg.move_limit       <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            sss_pkg::REG_THRESHOLD:  prdata = 32'(cfg_reg.threshold_tenths);
            sss_pkg::REG_GRID_ROWS:  prdata = 32'(cfg_reg.grid_rows);
            sss_pkg::REG_BASE_INDEX: prdata = 32'(cfg_reg.base_index);
            sss_pkg::REG_FIRST_EVAL: prdata = 32'(cfg_reg.first_eval_row);
            sss_pkg::REG_LAST_EVAL:  prdata = 32'(cfg_reg.last_eval_row);
            sss_pkg::REG_MOVE_LIMIT: prdata = 32'(cfg_reg.move_limit);
            default:                 prdata = '0;
        endcase
    end

    sss_front #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_stream (cell_stream),
        .cfg         (cfg_reg),
        .q_full      (full),
        .q_push      (push),
        .q_data      (push_data)
    );

    sss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    sss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (empty),
        .q_head        (head),
        .q_pop         (pop),
        .result_stream (result_stream)
    );

endmodule

### tb/sss_result_checker.sv
// Checker for the stencil unit: tracks register writes, predicts each result and compares.
`timescale 1ns / 1ps

module sss_result_checker #(
    parameter int COLUMNS  = 32,
    parameter int MAX_ROWS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sss_cell_if                        cells,
    sss_result_if                      results,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sss_pkg::ADDR_W-1:0] paddr,
    input  logic [sss_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    output int                         mismatches,
    output int                         pending
);
    import sss_pkg::*;

    typedef struct packed {
        logic [15:0] cell_index;
        logic [1:0]  kind;
        logic [3:0]  same_count;
        logic [3:0]  neighbour_count;
        logic        unsatisfied;
        logic        selected_to_move;
        logic        last_of_run;
    } verdict_t;

    verdict_t   expected_verdicts[$];
    cfg_t       cfg;
    logic [1:0] line_store [3][COLUMNS];
    logic [6:0] row_pos;
    int         col_pos;
    logic [11:0] moved_agents;
    int         fault_count;

    assign mismatches = fault_count;

    function automatic logic [1:0] cell_at(int row, int col);
        return line_store[row % 3][col];
    endfunction

    // Neighbourhood count and move selection for one reported cell.
    task automatic score_cell(int row, int col, bit below, bit last);
        verdict_t   v;
        logic [1:0] k;
        int         nb;
        int         same;
        int         rr;
        int         cc;
        bit         evaluated;
        k    = cell_at(row, col);
        nb   = 0;
        same = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = row + dr;
                cc = col + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && !(dr == 1 && !below)
                    && cc >= 0 && cc < COLUMNS)
                begin
                    nb++;
                    if (k != KIND_EMPTY && cell_at(rr, cc) == k)
                        same++;
                end
            end
        end
        evaluated = k != KIND_EMPTY && row >= int'(cfg.first_eval_row)
                    && row <= int'(cfg.last_eval_row);
        v.unsatisfied      = evaluated && (same * 1000 < int'(cfg.threshold_tenths) * nb);
        v.selected_to_move = v.unsatisfied && (moved_agents < cfg.move_limit);
        if (v.selected_to_move)
            moved_agents = moved_agents + 12'd1;
        v.cell_index      = cfg.base_index + 16'(row * COLUMNS + col);
        v.kind            = k;
        v.same_count      = 4'(same);
        v.neighbour_count = 4'(nb);
        v.last_of_run     = last;
        expected_verdicts.push_back(v);
    endtask

    // Store one arriving cell and queue the results it releases.
    task automatic absorb_cell(logic [1:0] kind_in);
        logic [1:0] k;
        int         rows;
        int         r;
        int         c;
        bit         fin;
        k    = (kind_in == KIND_INVALID) ? KIND_EMPTY : kind_in;
        rows = int'(cfg.grid_rows);
        if (rows < 2)
            rows = 2;
        if (rows > MAX_ROWS)
            rows = MAX_ROWS;
        r   = int'(row_pos);
        c   = col_pos;
        fin = r >= rows - 1;
        line_store[r % 3][c] = k;
        if (r >= 1 && c >= 1)
            score_cell(r - 1, c - 1, 1'b1, 1'b0);
        if (fin && r >= 1 && c == 1)
            score_cell(r, 0, 1'b0, 1'b0);
        if (c == COLUMNS - 1)
        begin
            if (r >= 1)
                score_cell(r - 1, COLUMNS - 1, 1'b1, 1'b0);
            if (fin)
            begin
                for (int x = 1; x < COLUMNS; x++)
                    score_cell(r, x, 1'b0, x == COLUMNS - 1);
                row_pos      = '0;
                col_pos      = 0;
                moved_agents = '0;
            end
            else
            begin
                col_pos = 0;
                row_pos = row_pos + 7'd1;
            end
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD:  cfg.threshold_tenths = data[9:0];
            REG_GRID_ROWS:  cfg.grid_rows        = data[6:0];
            REG_BASE_INDEX: cfg.base_index       = data[15:0];
            REG_FIRST_EVAL: cfg.first_eval_row   = data[5:0];
            REG_LAST_EVAL:  cfg.last_eval_row    = data[5:0];
            REG_MOVE_LIMIT: cfg.move_limit       = data[11:0];
            default:        ;
        endcase
    endtask

    function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endfunction

    task automatic compare_result();
        verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            $error("cell_index: expected none, actual %0d", results.cell_index);
            fault_count++;
        end
        else
        begin
            want = expected_verdicts.pop_front();
            field_check("cell_index", want.cell_index, results.cell_index);
            field_check("kind", 16'(want.kind), 16'(results.kind));
            field_check("same_count", 16'(want.same_count), 16'(results.same_count));
            field_check("neighbour_count", 16'(want.neighbour_count),
                        16'(results.neighbour_count));
            field_check("unsatisfied", 16'(want.unsatisfied), 16'(results.unsatisfied));
            field_check("selected_to_move", 16'(want.selected_to_move),
                        16'(results.selected_to_move));
            field_check("last_of_run", 16'(want.last_of_run), 16'(results.last_of_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_verdicts.delete();
            cfg.threshold_tenths = RST_THRESHOLD;
            cfg.grid_rows        = RST_GRID_ROWS;
            cfg.base_index       = RST_BASE_INDEX;
            cfg.first_eval_row   = RST_FIRST_EVAL;
            cfg.last_eval_row    = RST_LAST_EVAL;
            cfg.move_limit       = RST_MOVE_LIMIT;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < COLUMNS; j++)
                    line_store[i][j] = KIND_EMPTY;
            row_pos      = '0;
            col_pos      = 0;
            moved_agents = '0;
            fault_count  = 0;
            pending     <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
                compare_result();
            if (cells.valid && cells.ready)
                absorb_cell(cells.cell_kind);
            if (psel && penable && pwrite && pready)
                write_register(paddr[ADDR_W-1:2], pwdata);
            pending <= expected_verdicts.size();
        end
    end

endmodule

### tb/segregation_satisfaction_stencil_unit_tb.sv
// Testbench top for the stencil unit: cell stimulus, register phases, pacing and verdict.
`timescale 1ns / 1ps

module segregation_satisfaction_stencil_unit_tb;
    import sss_pkg::*;

    localparam int COLUMNS       = 32;
    localparam int MAX_ROWS      = 64;
    localparam int SETTLE_CYCLES = COLUMNS + 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [1:0] DIRECTED_KINDS [24] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd0, 2'd0, 2'd3, 2'd3, 2'd1, 2'd2,
        2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                pending;
    bit                pacing = 1'b1;
    logic [1:0]        last_kind = KIND_EMPTY;

    sss_cell_if   cells ();
    sss_result_if results ();

    segregation_satisfaction_stencil_unit #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_stream   (cells),
        .result_stream (results),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sss_result_checker #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .results    (results),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] rows,
                                 input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] first,
                                 input logic [DATA_W-1:0] last, input logic [DATA_W-1:0] limit);
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_GRID_ROWS, rows);
        apb_write(REG_BASE_INDEX, base);
        apb_write(REG_FIRST_EVAL, first);
        apb_write(REG_LAST_EVAL, last);
        apb_write(REG_MOVE_LIMIT, limit);
    endtask

    task automatic send_cell(input logic [1:0] kind);
        if (pacing && $urandom_range(0, 4) == 0)
        begin
            cells.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        cells.valid     <= 1'b1;
        cells.cell_kind <= kind;
        last_kind        = kind;
        @(posedge clk);
        while (!cells.ready)
            @(posedge clk);
    endtask

    // Clustered kinds so that both satisfied and unsatisfied agents show up.
    function automatic logic [1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return KIND_INVALID;
        if (roll < 55)
            return last_kind;
        return 2'($urandom_range(0, 2));
    endfunction

    task automatic stream_random(input int count);
        for (int i = 0; i < count; i++)
            send_cell(pick_kind());
    endtask

    // Drain all expected results, then let the final-row readback finish.
    task automatic settle();
        cells.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : result_pacing
        results.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (pacing && $urandom_range(0, 2) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
            results.ready <= 1'b1;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cells.valid && cells.ready) || (results.valid && results.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** segregation_satisfaction_stencil_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cells.valid     <= 1'b0;
        cells.cell_kind <= KIND_EMPTY;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two-row grid (row count 0 clamps), nobody can be satisfied, no moves, index wrap
        set_registers(32'd1023, 32'd0, 32'hFFFF, 32'd0, 32'd63, 32'd0);
        for (int i = 0; i < 24; i++)
            send_cell(DIRECTED_KINDS[i]);
        stream_random(40);
        settle();

        // three rows, middle row evaluated, few moves
        set_registers(32'd500, 32'd3, 32'h0100, 32'd1, 32'd1, 32'd3);
        stream_random(96);
        settle();

        // oversized row count, stop partway into the third row
        set_registers(32'd1000, 32'd127, 32'd63487, 32'd1, 32'd63, 32'hFFF);
        stream_random(70);
        settle();

        // row count lowered below the current row, empty evaluation window
        set_registers(32'd0, 32'd1, 32'h1234, 32'd63, 32'd0, 32'd2048);
        stream_random(26);
        settle();

        pacing = 1'b0;
        set_registers($urandom_range(0, 1000), 32'd2, $urandom_range(0, 65535), 32'd0,
                      32'd1, $urandom_range(0, 8));
        stream_random(64);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("** segregation_satisfaction_stencil_unit: PASSED **");
        else
            $display("** segregation_satisfaction_stencil_unit: FAILED **");
        $finish;
    end

endmodule
